FILE: src/sfwo_pkg.sv
// Shared types and constants for the steered four-wheel odometry block.
// Holds the CORDIC angle table, the per-wheel geometry and the register codes.
// No dependencies.
`timescale 1ns / 1ps

package sfwo_pkg;

    localparam int NUM_WHEELS   = 4;
    localparam int CORDIC_STEPS = 16;
    localparam int DIV_STEPS    = 41;

    localparam logic [15:0] PIVOT_SPACING_RESET  = 16'd11141;
    localparam logic [15:0] PIVOT_TO_WHEEL_RESET = 16'd2949;

    localparam logic [0:0] CFG_PIVOT_SPACING  = 1'b0;
    localparam logic [0:0] CFG_PIVOT_TO_WHEEL = 1'b1;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    localparam logic signed [23:0] ATAN_TAB [CORDIC_STEPS] = '{
        24'sd1474560, 24'sd870484, 24'sd459940, 24'sd233473,
        24'sd117189,  24'sd58652,  24'sd29333,  24'sd14667,
        24'sd7334,    24'sd3667,   24'sd1833,   24'sd917,
        24'sd458,     24'sd229,    24'sd115,    24'sd57
    };

    localparam logic [40:0] TERM_LIMIT = 41'h100_0000_0000;

    typedef struct packed {
        logic               use_right;
        logic               servo_neg;
        logic signed [17:0] mount;
        logic               sa_neg;
        logic               ca_neg;
        logic               rear;
    } wheel_cfg_t;

    // Wheel order: front right, front left, rear left, rear right.
    localparam wheel_cfg_t WHEEL_CFG [NUM_WHEELS] = '{
        '{1'b1, 1'b0, -18'sd17280, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b1,  18'sd17280, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0,  18'sd28800, 1'b0, 1'b1, 1'b1},
        '{1'b1, 1'b1, -18'sd28800, 1'b1, 1'b1, 1'b1}
    };

endpackage

FILE: src/sfwo_lane.sv
// One wheel lane: angle reduction, pipelined CORDIC, lever arm geometry and a
// pipelined restoring divider for the yaw term. Depends on sfwo_pkg.
`timescale 1ns / 1ps

module sfwo_lane (
    input  logic                    aclk,
    input  logic                    en,
    input  sfwo_pkg::wheel_cfg_t    wheel,
    input  logic [15:0]             servo,
    input  logic signed [15:0]      speed,
    input  logic [15:0]             pivot_spacing,
    input  logic [15:0]             pivot_to_wheel,
    output logic signed [31:0]      cv,
    output logic signed [31:0]      sv,
    output logic signed [41:0]      term
);
    import sfwo_pkg::*;

    // Angle reduction stages.
    logic signed [17:0] ang_reg;
    logic signed [15:0] v1_reg, v2_reg, v3_reg;
    logic [15:0]        a_reg;
    logic signed [23:0] z0_reg;
    logic               neg0_reg;

    logic signed [17:0] servo_s;
    logic [17:0]        m0, m1, m2;
    logic [17:0]        m3;
    logic signed [16:0] fold;
    logic               fold_neg;

    assign servo_s = $signed({2'b00, servo});

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg <= (wheel.servo_neg ? -servo_s : servo_s) + wheel.mount;
            v1_reg  <= speed;
        end
    end

    always_comb begin
        m0 = ang_reg + 18'd138240;
        m1 = (m0 >= 18'd184320) ? m0 - 18'd184320 : m0;
        m2 = (m1 >= 18'd92160) ? m1 - 18'd92160 : m1;
        m3 = (m2 >= 18'd46080) ? m2 - 18'd46080 : m2;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg  <= m3[15:0];
            v2_reg <= v1_reg;
        end
    end

    always_comb begin
        fold_neg = 1'b0;
        fold     = $signed({1'b0, a_reg});
        if (a_reg > 16'd11520 && a_reg < 16'd34560) begin
            fold     = $signed({1'b0, a_reg}) - 17'sd23040;
            fold_neg = 1'b1;
        end else if (a_reg >= 16'd34560) begin
            fold = $signed({1'b0, a_reg}) - 17'sd46080;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z0_reg   <= {fold[15:0], 8'b0};
            neg0_reg <= fold_neg;
            v3_reg   <= v2_reg;
        end
    end

    // CORDIC, one rotation per stage.
    logic signed [31:0] x_reg [CORDIC_STEPS];
    logic signed [31:0] y_reg [CORDIC_STEPS];
    logic signed [23:0] z_reg [CORDIC_STEPS-1];
    logic               cneg_reg [CORDIC_STEPS];
    logic signed [15:0] cv_reg [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [31:0] x_in, y_in, x_sh, y_sh;
        logic signed [23:0] z_in;
        logic               neg_in;
        logic signed [15:0] v_in;

        if (i == 0) begin : g_first
            assign x_in   = CORDIC_GAIN;
            assign y_in   = '0;
            assign z_in   = z0_reg;
            assign neg_in = neg0_reg;
            assign v_in   = v3_reg;
        end else begin : g_next
            assign x_in   = x_reg[i-1];
            assign y_in   = y_reg[i-1];
            assign z_in   = z_reg[i-1];
            assign neg_in = cneg_reg[i-1];
            assign v_in   = cv_reg[i-1];
        end

        assign x_sh = x_in >>> i;
        assign y_sh = y_in >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_in >= 0) begin
                    x_reg[i] <= x_in - y_sh;
                    y_reg[i] <= y_in + x_sh;
                end else begin
                    x_reg[i] <= x_in + y_sh;
                    y_reg[i] <= y_in - x_sh;
                end
                cneg_reg[i] <= neg_in;
                cv_reg[i]   <= v_in;
            end
        end

        if (i < CORDIC_STEPS - 1) begin : g_z
            always_ff @(posedge aclk) begin
                if (en) begin
                    z_reg[i] <= (z_in >= 0) ? z_in - ATAN_TAB[i] : z_in + ATAN_TAB[i];
                end
            end
        end
    end

    // Rounding to Q14.
    logic signed [32:0] y_rnd, x_rnd;
    logic signed [15:0] s_raw, c_raw;
    logic signed [15:0] s20_reg, c20_reg, v20_reg;

    assign y_rnd = 33'(y_reg[CORDIC_STEPS-1]) + 33'sd32768;
    assign x_rnd = 33'(x_reg[CORDIC_STEPS-1]) + 33'sd32768;
    assign s_raw = y_rnd[31:16];
    assign c_raw = x_rnd[31:16];

    always_ff @(posedge aclk) begin
        if (en) begin
            s20_reg <= cneg_reg[CORDIC_STEPS-1] ? -s_raw : s_raw;
            c20_reg <= cneg_reg[CORDIC_STEPS-1] ? -c_raw : c_raw;
            v20_reg <= cv_reg[CORDIC_STEPS-1];
        end
    end

    // Products with the pivot offset and the wheel speed.
    logic signed [16:0] sm, cm;
    logic signed [17:0] d2;
    logic signed [34:0] pds_reg, pdc_reg;
    logic signed [31:0] cv_out_reg, sv_out_reg;
    logic signed [15:0] s21_reg, c21_reg, v21_reg;

    assign sm = wheel.rear ? -17'(s20_reg) : 17'(s20_reg);
    assign cm = wheel.rear ? -17'(c20_reg) : 17'(c20_reg);
    assign d2 = $signed({1'b0, pivot_to_wheel, 1'b0});

    always_ff @(posedge aclk) begin
        if (en) begin
            pds_reg    <= d2 * sm;
            pdc_reg    <= d2 * cm;
            cv_out_reg <= c20_reg * v20_reg;
            sv_out_reg <= s20_reg * v20_reg;
            s21_reg    <= s20_reg;
            c21_reg    <= c20_reg;
            v21_reg    <= v20_reg;
        end
    end

    assign cv = cv_out_reg;
    assign sv = sv_out_reg;

    // Lever arm.
    logic signed [34:0] pds_rnd, pdc_rnd;
    logic signed [21:0] l_s, sal, cal, dx_full, dy_full;
    logic signed [18:0] dx_reg, dy_reg;
    logic signed [15:0] s22_reg, c22_reg, v22_reg;

    assign pds_rnd = pds_reg + 35'sd8192;
    assign pdc_rnd = pdc_reg + 35'sd8192;
    assign l_s     = $signed({6'b0, pivot_spacing});
    assign sal     = wheel.sa_neg ? -l_s : l_s;
    assign cal     = wheel.ca_neg ? -l_s : l_s;
    assign dx_full = -(sal + 22'($signed(pds_rnd[34:14])));
    assign dy_full = cal + 22'($signed(pdc_rnd[34:14]));

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg  <= dx_full[18:0];
            dy_reg  <= dy_full[18:0];
            s22_reg <= s21_reg;
            c22_reg <= c21_reg;
            v22_reg <= v21_reg;
        end
    end

    // Projections and squared arm length.
    logic signed [34:0] dxs_reg, dyc_reg;
    logic signed [37:0] dxx_full, dyy_full;
    logic [35:0]        dxx_reg, dyy_reg;
    logic signed [15:0] s23_reg, v23_reg;

    assign dxx_full = dx_reg * dx_reg;
    assign dyy_full = dy_reg * dy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dxs_reg <= dx_reg * s22_reg;
            dyc_reg <= dy_reg * c22_reg;
            dxx_reg <= dxx_full[35:0];
            dyy_reg <= dyy_full[35:0];
            s23_reg <= s22_reg;
            v23_reg <= v22_reg;
        end
    end

    logic signed [35:0] p_reg;
    logic [36:0]        n24_reg;
    logic signed [15:0] s24_reg, v24_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg   <= 36'(dyc_reg) - 36'(dxs_reg);
            n24_reg <= {1'b0, dxx_reg} + {1'b0, dyy_reg};
            s24_reg <= s23_reg;
            v24_reg <= v23_reg;
        end
    end

    logic signed [16:0] ns;
    logic signed [52:0] ps_reg;
    logic [36:0]        n25_reg;
    logic signed [15:0] v25_reg;

    assign ns = -17'(s24_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            ps_reg  <= p_reg * ns;
            n25_reg <= n24_reg;
            v25_reg <= v24_reg;
        end
    end

    logic signed [68:0] num_full;
    logic signed [63:0] num_reg;
    logic [36:0]        n26_reg;

    assign num_full = ps_reg * v25_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg <= num_full[63:0];
            n26_reg <= n25_reg;
        end
    end

    logic [63:0] num_abs;
    logic [62:0] mag_reg;
    logic        neg27_reg;
    logic [36:0] n27_reg;

    assign num_abs = num_reg[63] ? -num_reg : num_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg   <= num_abs[62:0];
            neg27_reg <= num_reg[63];
            n27_reg   <= n26_reg;
        end
    end

    logic [63:0] dvd_reg;
    logic        neg28_reg;
    logic [36:0] n28_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dvd_reg   <= {1'b0, mag_reg} + {28'b0, n27_reg[36:1]};
            neg28_reg <= neg27_reg;
            n28_reg   <= n27_reg;
        end
    end

    logic [63:0] rem29_reg;
    logic [36:0] n29_reg;
    logic        neg29_reg, ovf29_reg, zero29_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem29_reg  <= dvd_reg;
            n29_reg    <= n28_reg;
            neg29_reg  <= neg28_reg;
            ovf29_reg  <= {14'b0, dvd_reg} >= {n28_reg, 41'b0};
            zero29_reg <= (n28_reg == '0);
        end
    end

    // Restoring divider, one quotient bit per stage, most significant first.
    logic [63:0] rem_reg  [DIV_STEPS-1];
    logic [36:0] dn_reg   [DIV_STEPS-1];
    logic [40:0] q_reg    [DIV_STEPS];
    logic        dneg_reg [DIV_STEPS];
    logic        dovf_reg [DIV_STEPS];
    logic        dzero_reg[DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int BIT = DIV_STEPS - 1 - j;
        logic [63:0] rem_in;
        logic [36:0] n_in;
        logic [40:0] q_in;
        logic        neg_in, ovf_in, zero_in;
        logic [77:0] dsh;
        logic        ge;

        if (j == 0) begin : g_first
            assign rem_in  = rem29_reg;
            assign n_in    = n29_reg;
            assign q_in    = '0;
            assign neg_in  = neg29_reg;
            assign ovf_in  = ovf29_reg;
            assign zero_in = zero29_reg;
        end else begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign n_in    = dn_reg[j-1];
            assign q_in    = q_reg[j-1];
            assign neg_in  = dneg_reg[j-1];
            assign ovf_in  = dovf_reg[j-1];
            assign zero_in = dzero_reg[j-1];
        end

        assign dsh = {41'b0, n_in} << BIT;
        assign ge  = {14'b0, rem_in} >= dsh;

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[j]     <= q_in | (41'(ge) << BIT);
                dneg_reg[j]  <= neg_in;
                dovf_reg[j]  <= ovf_in;
                dzero_reg[j] <= zero_in;
            end
        end

        if (j < DIV_STEPS - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= ge ? rem_in - dsh[63:0] : rem_in;
                    dn_reg[j]  <= n_in;
                end
            end
        end
    end

    logic [40:0]        q_fin, t_mag;
    logic signed [41:0] term_reg;

    assign q_fin = q_reg[DIV_STEPS-1];

    always_comb begin
        if (dzero_reg[DIV_STEPS-1]) begin
            t_mag = '0;
        end else if (dovf_reg[DIV_STEPS-1] || q_fin > TERM_LIMIT) begin
            t_mag = TERM_LIMIT;
        end else begin
            t_mag = q_fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            term_reg <= dneg_reg[DIV_STEPS-1] ? -$signed({1'b0, t_mag}) : $signed({1'b0, t_mag});
        end
    end

    assign term = term_reg;

endmodule

FILE: src/steered_four_wheel_odometry.sv
// Top level of the steered four-wheel odometry block: four wheel lanes, the
// sums and saturation of the body velocities, and the configuration registers.
// Depends on sfwo_pkg and sfwo_lane.
`timescale 1ns / 1ps

// The block takes one beat per clock cycle unless the output is held; its
// pipeline depth is set by the 16 CORDIC stages and the 41 stage divider in
// each wheel lane. The whole pipeline advances together, so when the output is
// held by a low m_ready no new beat is taken until the waiting result leaves.
// Configuration registers may be written only while no beat is in flight.
module steered_four_wheel_odometry (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [0:0]         cfg_wr_index,
    input  logic [15:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_left_servo_angle,
    input  logic [15:0]        s_right_servo_angle,
    input  logic signed [15:0] s_speed_front_right,
    input  logic signed [15:0] s_speed_front_left,
    input  logic signed [15:0] s_speed_rear_left,
    input  logic signed [15:0] s_speed_rear_right,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_velocity_x,
    output logic signed [15:0] m_velocity_y,
    output logic signed [23:0] m_yaw_rate
);
    import sfwo_pkg::*;

    localparam int PIPE_DEPTH = 72;
    localparam int VEL_DELAY  = 50;

    logic [15:0] pivot_spacing_reg, pivot_to_wheel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pivot_spacing_reg  <= PIVOT_SPACING_RESET;
            pivot_to_wheel_reg <= PIVOT_TO_WHEEL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_PIVOT_SPACING:  pivot_spacing_reg  <= cfg_wr_data;
                CFG_PIVOT_TO_WHEEL: pivot_to_wheel_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    logic                  en;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[PIPE_DEPTH-2:0], s_valid};
            m_valid_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    logic signed [15:0] speed [NUM_WHEELS];
    logic signed [31:0] cv [NUM_WHEELS];
    logic signed [31:0] sv [NUM_WHEELS];
    logic signed [41:0] term [NUM_WHEELS];

    assign speed[0] = s_speed_front_right;
    assign speed[1] = s_speed_front_left;
    assign speed[2] = s_speed_rear_left;
    assign speed[3] = s_speed_rear_right;

    for (genvar k = 0; k < NUM_WHEELS; k++) begin : g_lane
        sfwo_lane u_lane (
            .aclk           (aclk),
            .en             (en),
            .wheel          (WHEEL_CFG[k]),
            .servo          (WHEEL_CFG[k].use_right ? s_right_servo_angle
                                                    : s_left_servo_angle),
            .speed          (speed[k]),
            .pivot_spacing  (pivot_spacing_reg),
            .pivot_to_wheel (pivot_to_wheel_reg),
            .cv             (cv[k]),
            .sv             (sv[k]),
            .term           (term[k])
        );
    end

    logic signed [33:0] sx_next, sy_next, sx_reg, sy_reg;
    logic signed [33:0] sx_rnd, sy_rnd;
    logic signed [17:0] vx_sh, vy_sh;
    logic signed [15:0] vx_sat, vy_sat;
    logic signed [15:0] vel_x_reg [VEL_DELAY];
    logic signed [15:0] vel_y_reg [VEL_DELAY];

    always_comb begin
        sx_next = '0;
        sy_next = '0;
        for (int k = 0; k < NUM_WHEELS; k++) begin
            sx_next = sx_next + 34'(cv[k]);
            sy_next = sy_next - 34'(sv[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
    end

    assign sx_rnd = sx_reg + 34'sd32768;
    assign sy_rnd = sy_reg + 34'sd32768;
    assign vx_sh  = sx_rnd[33:16];
    assign vy_sh  = sy_rnd[33:16];
    assign vx_sat = (vx_sh > 18'sd32767) ? 16'sh7fff :
                    (vx_sh < -18'sd32768) ? 16'sh8000 : vx_sh[15:0];
    assign vy_sat = (vy_sh > 18'sd32767) ? 16'sh7fff :
                    (vy_sh < -18'sd32768) ? 16'sh8000 : vy_sh[15:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            vel_x_reg[0] <= vx_sat;
            vel_y_reg[0] <= vy_sat;
            for (int k = 1; k < VEL_DELAY; k++) begin
                vel_x_reg[k] <= vel_x_reg[k-1];
                vel_y_reg[k] <= vel_y_reg[k-1];
            end
        end
    end

    logic signed [43:0] st_next, st_reg, st_rnd;
    logic signed [30:0] yaw_sh;
    logic signed [23:0] yaw_sat;

    always_comb begin
        st_next = '0;
        for (int k = 0; k < NUM_WHEELS; k++) begin
            st_next = st_next + 44'(term[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign st_rnd  = st_reg + 44'sd4096;
    assign yaw_sh  = st_rnd[43:13];
    assign yaw_sat = (yaw_sh > 31'sd8388607) ? 24'sh7fffff :
                     (yaw_sh < -31'sd8388608) ? 24'sh800000 : yaw_sh[23:0];

    logic signed [15:0] m_velocity_x_reg, m_velocity_y_reg;
    logic signed [23:0] m_yaw_rate_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_velocity_x_reg <= vel_x_reg[VEL_DELAY-1];
            m_velocity_y_reg <= vel_y_reg[VEL_DELAY-1];
            m_yaw_rate_reg   <= yaw_sat;
        end
    end

    assign m_velocity_x = m_velocity_x_reg;
    assign m_velocity_y = m_velocity_y_reg;
    assign m_yaw_rate   = m_yaw_rate_reg;

endmodule

FILE: verif/sfwo_checker.sv
// Checker for the steered four-wheel odometry block: predicts each result from
// the accepted input beat and the register writes, and compares in order.
// Depends on sfwo_pkg.
`timescale 1ns / 1ps

module sfwo_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [0:0]         cfg_wr_index,
    input  logic [15:0]        cfg_wr_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [15:0]        s_left_servo_angle,
    input  logic [15:0]        s_right_servo_angle,
    input  logic signed [15:0] s_speed_front_right,
    input  logic signed [15:0] s_speed_front_left,
    input  logic signed [15:0] s_speed_rear_left,
    input  logic signed [15:0] s_speed_rear_right,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_velocity_x,
    input  logic signed [15:0] m_velocity_y,
    input  logic signed [23:0] m_yaw_rate,
    output int                 fail_count,
    output int                 pending
);
    import sfwo_pkg::*;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [23:0] yaw;
    } body_motion_t;

    body_motion_t motion_q[$];
    logic [15:0] spacing, offset;

    assign pending = motion_q.size();

    function automatic longint shr_floor(longint v, int k);
        return v >>> k;
    endfunction

    function automatic void wheel_trig(input int ang, output longint s, output longint c);
        int a;
        bit neg;
        longint x, y, z, nx;
        a = ((ang % 46080) + 46080) % 46080;
        neg = 0;
        x = 652032874;
        y = 0;
        if (a > 11520 && a < 34560) begin
            a -= 23040;
            neg = 1;
        end else if (a >= 34560) begin
            a -= 46080;
        end
        z = longint'(a) * 256;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - shr_floor(y, i);
                y = y + shr_floor(x, i);
                z -= ATAN_TAB[i];
            end else begin
                nx = x + shr_floor(y, i);
                y = y - shr_floor(x, i);
                z += ATAN_TAB[i];
            end
            x = nx;
        end
        s = shr_floor(y + 32768, 16);
        c = shr_floor(x + 32768, 16);
        if (neg) begin
            s = -s;
            c = -c;
        end
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic body_motion_t predict_motion(logic [15:0] sl, logic [15:0] sr,
                                                    logic signed [15:0] spd [NUM_WHEELS]);
        longint sx, sy, st, len, d2, v, s, c, sm, cm, dx, dy, n2, p, num, t;
        longint unsigned mag, q;
        int ang;
        body_motion_t r;
        sx = 0; sy = 0; st = 0;
        len = spacing;
        d2 = 2 * longint'(offset);
        for (int i = 0; i < NUM_WHEELS; i++) begin
            v = spd[i];
            ang = (WHEEL_CFG[i].use_right ? int'(sr) : int'(sl));
            if (WHEEL_CFG[i].servo_neg) ang = -ang;
            ang += WHEEL_CFG[i].mount;
            wheel_trig(ang, s, c);
            sx += c * v;
            sy -= s * v;
            sm = WHEEL_CFG[i].rear ? -s : s;
            cm = WHEEL_CFG[i].rear ? -c : c;
            dx = -((WHEEL_CFG[i].sa_neg ? -len : len) + shr_floor(d2 * sm + 8192, 14));
            dy = (WHEEL_CFG[i].ca_neg ? -len : len) + shr_floor(d2 * cm + 8192, 14);
            n2 = dx * dx + dy * dy;
            t = 0;
            if (n2 != 0) begin
                p = -dx * s + dy * c;
                num = p * (-s) * v;
                mag = num < 0 ? longint'(-num) : num;
                q = (mag + longint'(n2) / 2) / longint'(n2);
                if (q > (64'd1 << 40)) q = 64'd1 << 40;
                t = num < 0 ? -longint'(q) : longint'(q);
            end
            st += t;
        end
        r.vx = 16'(clamp(shr_floor(sx + 32768, 16), -32768, 32767));
        r.vy = 16'(clamp(shr_floor(sy + 32768, 16), -32768, 32767));
        r.yaw = 24'(clamp(shr_floor(st + 4096, 13), -8388608, 8388607));
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        logic signed [15:0] spd [NUM_WHEELS];
        body_motion_t exp_m;
        if (!aresetn) begin
            spacing <= PIVOT_SPACING_RESET;
            offset <= PIVOT_TO_WHEEL_RESET;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_wr_index == CFG_PIVOT_SPACING) spacing <= cfg_wr_data;
                else if (cfg_wr_index == CFG_PIVOT_TO_WHEEL) offset <= cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                spd[0] = s_speed_front_right;
                spd[1] = s_speed_front_left;
                spd[2] = s_speed_rear_left;
                spd[3] = s_speed_rear_right;
                motion_q.push_back(predict_motion(s_left_servo_angle, s_right_servo_angle,
                                                  spd));
            end
            if (m_valid && m_ready) begin
                if (motion_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    exp_m = motion_q.pop_front();
                    if (m_velocity_x !== exp_m.vx)
                        report_mismatch($sformatf("velocity_x %0d, expected %0d",
                                                  m_velocity_x, exp_m.vx));
                    if (m_velocity_y !== exp_m.vy)
                        report_mismatch($sformatf("velocity_y %0d, expected %0d",
                                                  m_velocity_y, exp_m.vy));
                    if (m_yaw_rate !== exp_m.yaw)
                        report_mismatch($sformatf("yaw_rate %0d, expected %0d",
                                                  m_yaw_rate, exp_m.yaw));
                end
            end
        end
    end

endmodule

FILE: verif/steered_four_wheel_odometry_tb.sv
// Testbench top for the steered four-wheel odometry block: drives register
// writes and input beats with random idling, and gives the verdict.
// Depends on sfwo_pkg, sfwo_checker and the block.
`timescale 1ns / 1ps

module steered_four_wheel_odometry_tb;
    import sfwo_pkg::*;

    logic               aclk, aresetn;
    logic               cfg_wr_en;
    logic [0:0]         cfg_wr_index;
    logic [15:0]        cfg_wr_data;
    logic               s_valid, s_ready;
    logic [15:0]        s_left_servo_angle, s_right_servo_angle;
    logic signed [15:0] s_speed_front_right, s_speed_front_left;
    logic signed [15:0] s_speed_rear_left, s_speed_rear_right;
    logic               m_valid, m_ready;
    logic signed [15:0] m_velocity_x, m_velocity_y;
    logic signed [23:0] m_yaw_rate;
    int                 fail_count, pending;
    int                 send_idle, recv_idle;

    steered_four_wheel_odometry DUT (.*);
    sfwo_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 0;
        else m_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Writes the pivot spacing, then the pivot offset, on consecutive edges.
    task automatic write_config(input logic [15:0] spc_val, input logic [15:0] ofs_val);
        cfg_wr_en <= 1;
        cfg_wr_index <= CFG_PIVOT_SPACING;
        cfg_wr_data <= spc_val;
        @(posedge aclk);
        cfg_wr_index <= CFG_PIVOT_TO_WHEEL;
        cfg_wr_data <= ofs_val;
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    task automatic send_beat(input logic [15:0] sl, input logic [15:0] sr,
                             input logic [15:0] fr, input logic [15:0] fl,
                             input logic [15:0] rl, input logic [15:0] rr);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_left_servo_angle <= sl;
        s_right_servo_angle <= sr;
        s_speed_front_right <= fr;
        s_speed_front_left <= fl;
        s_speed_rear_left <= rl;
        s_speed_rear_right <= rr;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [15:0] rand_speed();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            1: return 16'($urandom_range(2048) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(5))
            0: return 16'($urandom);
            1: return 16'(11520 * $urandom_range(3) + $urandom_range(2) - 1);
            default: return 16'($urandom_range(46079));
        endcase
    endfunction

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic run_phase(input int count, input int sidle, input int ridle);
        send_idle = sidle;
        recv_idle = ridle;
        repeat (count)
            send_beat(rand_angle(), rand_angle(), rand_speed(), rand_speed(),
                      rand_speed(), rand_speed());
        drain();
    endtask

    initial begin
        logic [15:0] spc [4] = '{16'd0, 16'd65535, 16'd11141, 16'd1};
        logic [15:0] ofs [4] = '{16'd0, 16'd65535, 16'd2949, 16'd40000};
        aresetn = 0;
        cfg_wr_en = 0;
        cfg_wr_index = CFG_PIVOT_SPACING;
        cfg_wr_data = 0;
        s_valid = 0;
        s_left_servo_angle = 0;
        s_right_servo_angle = 0;
        s_speed_front_right = 0;
        s_speed_front_left = 0;
        s_speed_rear_left = 0;
        s_speed_rear_right = 0;
        send_idle = 0;
        recv_idle = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_beat(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(16'd46079, 16'd46079, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_beat(16'hffff, 16'hffff, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_beat(16'd11520, 16'd34560, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_beat(16'd23040, 16'd0, 16'h1000, 16'h1000, 16'h1000, 16'h1000);
        send_beat(16'd5760, 16'd40320, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_beat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
        drain();
        // A zero arm length and a zero offset give degenerate lever arms.
        write_config(16'd0, 16'd0);
        send_beat(16'd11520, 16'd11520, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_beat(16'd0, 16'd23040, 16'h1234, 16'h7fff, 16'h8000, 16'h0fff);
        drain();
        write_config(16'd1, 16'd65535);
        send_beat(16'd20000, 16'd3000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
        drain();

        for (int k = 0; k < 4; k++) begin
            write_config(spc[k], ofs[k]);
            run_phase(50, 23, 71);
            run_phase(50, 71, 23);
            run_phase(35, 0, 0);
        end

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
src/sfwo_pkg.sv
src/sfwo_lane.sv
src/steered_four_wheel_odometry.sv
verif/sfwo_checker.sv
verif/steered_four_wheel_odometry_tb.sv
